/* hdl/sbsm_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbsm_pkg
// Shared types and constants of the serial bank switch mapper.
// ---------------------------------------------------------------------------
package sbsm_pkg;

	// Access kinds carried in the command field
	typedef enum logic [1:0] {
		CMD_CPU_READ  = 2'd0,
		CMD_CPU_WRITE = 2'd1,
		CMD_PPU_READ  = 2'd2,
		CMD_UNUSED    = 2'd3
	} cmd_t;

	// Load targets, address bits 14:13 of the fifth serial write
	typedef enum logic [1:0] {
		TGT_CONTROL  = 2'd0,
		TGT_CHR_LOW  = 2'd1,
		TGT_CHR_HIGH = 2'd2,
		TGT_PRG      = 2'd3
	} target_t;

	// Configuration register indexes
	typedef enum logic {
		CFG_PRG_COUNT = 1'b0,
		CFG_CHR_COUNT = 1'b1
	} cfg_index_t;

	localparam int OFFSET_W = 18;
	localparam int ADDR_W   = 16;
	localparam int DATA_W   = 8;
	localparam int MIRROR_W = 2;
	localparam int COUNT_W  = 5;

	localparam logic [4:0]         CTRL_RESET       = 5'h0C;
	localparam logic [4:0]         CTRL_PRG_16K     = 5'h0C;
	localparam logic [2:0]         SERIAL_LAST      = 3'd5;
	localparam logic [COUNT_W-1:0] PRG_COUNT_RESET  = 5'd8;
	localparam logic [COUNT_W-1:0] CHR_COUNT_RESET  = 5'd0;
	localparam logic [3:0]         PRG_HIGH_RESET   = 4'(PRG_COUNT_RESET - 5'd1);
	localparam logic [OFFSET_W-1:0] PPU_OUT_OF_RANGE = 18'h000FF;

	// Bank registers visible to the translator
	typedef struct packed {
		logic [4:0] control;
		logic [4:0] chr_low;
		logic [4:0] chr_high;
		logic [4:0] chr_whole;
		logic [2:0] prg_whole;
		logic [3:0] prg_low;
		logic [3:0] prg_high;
	} bank_state_t;

endpackage

/* hdl/serial_bank_switch_mapper.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// serial_bank_switch_mapper
// Serial-loaded cartridge bank mapper with streaming access and result ports.
// ---------------------------------------------------------------------------
// Usage:
//  - s_axis carries one bus access per transfer: command, address, data.
//    CPU writes drive the serial loader; CPU and PPU reads are translated.
//  - m_axis returns exactly one result per access: the ROM offset (zero for
//    writes and the unused command) and the mirror mode after the access.
//  - cfg carries writes of the PRG and CHR bank counts; always ready. Write
//    them only while no access is in flight.
//  - Path: an accepted access passes the input register, then the result
//    register, and shows on m_axis from the result register.
//  - Throughput: one access per cycle unless m_axis stalls; the loader and
//    translator form one logic level between input and result registers.
//  - Stall: when m_axis is held, the result register holds, the input
//    register fills, and then s_axis_tready drops until the result is taken.
//  - Reset: arst_n clears both pipeline stages, control = 16 KiB PRG mode,
//    high PRG bank = last bank, bank counts to 8 PRG and 0 CHR.
// ---------------------------------------------------------------------------
module serial_bank_switch_mapper (
	input  logic        clk,
	input  logic        arst_n,
	// access in: [1:0] command, [17:2] address, [25:18] data, rest zero
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,
	// result out: [17:0] mapped_offset, [19:18] mirror_mode, rest zero
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,
	// configuration write: index 0 prg_bank_count, 1 chr_bank_count
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [4:0]  cfg_data
);

	// input stage
	logic                          valid_s1;
	sbsm_pkg::cmd_t                cmd_s1;
	logic [sbsm_pkg::ADDR_W-1:0]   addr_s1;
	logic [sbsm_pkg::DATA_W-1:0]   data_s1;

	// result stage
	logic                          out_valid_q;
	logic [sbsm_pkg::OFFSET_W-1:0] offset_q;
	logic [sbsm_pkg::MIRROR_W-1:0] mirror_q;

	// configuration
	logic [sbsm_pkg::COUNT_W-1:0]  prg_count_q;
	logic [sbsm_pkg::COUNT_W-1:0]  chr_count_q;

	logic                          advance;
	sbsm_pkg::bank_state_t         bank;
	logic [4:0]                    ctrl_next;
	logic [sbsm_pkg::OFFSET_W-1:0] offset;

	// item moves to the result register when that register is free or drains
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// payload only, no reset needed
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cmd_s1  <= sbsm_pkg::cmd_t'(s_axis_tdata[1:0]);
			addr_s1 <= s_axis_tdata[17:2];
			data_s1 <= s_axis_tdata[25:18];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_count_q <= sbsm_pkg::PRG_COUNT_RESET;
			chr_count_q <= sbsm_pkg::CHR_COUNT_RESET;
		end else if (cfg_valid) begin
			unique case (sbsm_pkg::cfg_index_t'(cfg_index))
				sbsm_pkg::CFG_PRG_COUNT: prg_count_q <= cfg_data;
				sbsm_pkg::CFG_CHR_COUNT: chr_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// state updates only for CPU writes that leave the input stage
	sbsm_loader u_loader (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (advance && cmd_s1 == sbsm_pkg::CMD_CPU_WRITE),
		.wr_addr   (addr_s1),
		.wr_data   (data_s1),
		.prg_count (prg_count_q),
		.bank      (bank),
		.ctrl_next (ctrl_next)
	);

	// reads never change the banks, so the current registers serve them
	sbsm_translate u_translate (
		.cmd       (cmd_s1),
		.addr      (addr_s1),
		.bank      (bank),
		.chr_count (chr_count_q),
		.offset    (offset)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			offset_q <= offset;
			mirror_q <= ctrl_next[1:0];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0000, mirror_q, offset_q};

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("input stage item dropped while stalled");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_axis_tready)
		else $error("input stage empty but not ready");

	a_adv_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("advanced item missing from result register");

endmodule

/* hdl/sbsm_loader.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbsm_loader
// Serial shift loader and bank registers, updated by CPU write transfers.
// ---------------------------------------------------------------------------
module sbsm_loader (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [sbsm_pkg::ADDR_W-1:0]   wr_addr,
	input  logic [sbsm_pkg::DATA_W-1:0]   wr_data,
	input  logic [sbsm_pkg::COUNT_W-1:0]  prg_count,
	output sbsm_pkg::bank_state_t         bank,
	output logic [4:0]                    ctrl_next
);

	sbsm_pkg::bank_state_t bank_q, bank_d;
	logic [4:0]            shift_q, shift_d, shift_new;
	logic [2:0]            count_q, count_d, count_new;
	sbsm_pkg::target_t     target;

	assign shift_new = {wr_data[0], shift_q[4:1]};
	assign count_new = count_q + 3'd1;
	assign target    = sbsm_pkg::target_t'(wr_addr[14:13]);

	always_comb begin
		bank_d  = bank_q;
		shift_d = shift_q;
		count_d = count_q;
		if (wr_en) begin
			if (wr_data[7]) begin
				shift_d        = '0;
				count_d        = '0;
				bank_d.control = bank_q.control | sbsm_pkg::CTRL_PRG_16K;
			end else if (count_new != sbsm_pkg::SERIAL_LAST) begin
				shift_d = shift_new;
				count_d = count_new;
			end else begin
				shift_d = '0;
				count_d = '0;
				case (target)
					sbsm_pkg::TGT_CONTROL: bank_d.control = shift_new;
					sbsm_pkg::TGT_CHR_LOW: begin
						if (bank_q.control[4])
							bank_d.chr_low = shift_new;
						else
							bank_d.chr_whole = {shift_new[4:1], 1'b0};
					end
					sbsm_pkg::TGT_CHR_HIGH: begin
						if (bank_q.control[4])
							bank_d.chr_high = shift_new;
					end
					default: begin
						// PRG target, by PRG mode in control bits 3:2
						if (!bank_q.control[3]) begin
							bank_d.prg_whole = shift_new[3:1];
						end else if (!bank_q.control[2]) begin
							bank_d.prg_low  = '0;
							bank_d.prg_high = shift_new[3:0];
						end else begin
							bank_d.prg_low  = shift_new[3:0];
							bank_d.prg_high = 4'(prg_count - 5'd1);
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q          <= '0;
			count_q          <= '0;
			bank_q.control   <= sbsm_pkg::CTRL_RESET;
			bank_q.chr_low   <= '0;
			bank_q.chr_high  <= '0;
			bank_q.chr_whole <= '0;
			bank_q.prg_whole <= '0;
			bank_q.prg_low   <= '0;
			bank_q.prg_high  <= sbsm_pkg::PRG_HIGH_RESET;
		end else begin
			shift_q <= shift_d;
			count_q <= count_d;
			bank_q  <= bank_d;
		end
	end

	assign bank      = bank_q;
	assign ctrl_next = bank_d.control;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'd4)
		else $error("serial count beyond four");

	a_reset_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && wr_data[7] |=> count_q == 3'd0 && shift_q == 5'd0
			&& bank_q.control[3:2] == 2'b11)
		else $error("loader reset write not applied");

	a_chr_whole_even: assert property (@(posedge clk) disable iff (!arst_n)
		!bank_q.chr_whole[0])
		else $error("8 KiB CHR bank not even");

endmodule

/* hdl/sbsm_translate.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbsm_translate
// CPU and PPU address to ROM offset translation from the bank registers.
// ---------------------------------------------------------------------------
module sbsm_translate (
	input  sbsm_pkg::cmd_t                cmd,
	input  logic [sbsm_pkg::ADDR_W-1:0]   addr,
	input  sbsm_pkg::bank_state_t         bank,
	input  logic [sbsm_pkg::COUNT_W-1:0]  chr_count,
	output logic [sbsm_pkg::OFFSET_W-1:0] offset
);

	logic [sbsm_pkg::OFFSET_W-1:0] cpu_off, ppu_off;

	always_comb begin
		// 16 KiB mode splits 0x8000-0xFFFF in two halves
		if (bank.control[3] && addr[15])
			cpu_off = {(addr[14] ? bank.prg_high : bank.prg_low), addr[13:0]};
		else
			cpu_off = {bank.prg_whole, addr[14:0]};
	end

	always_comb begin
		if (chr_count == '0)
			ppu_off = {2'b00, addr};
		else if (bank.control[4]) begin
			if (addr[15:12] == 4'h0)
				ppu_off = {1'b0, bank.chr_low, addr[11:0]};
			else if (addr[15:12] == 4'h1)
				ppu_off = {1'b0, bank.chr_high, addr[11:0]};
			else
				ppu_off = sbsm_pkg::PPU_OUT_OF_RANGE;
		end else
			ppu_off = {1'b0, bank.chr_whole[4:1], addr[12:0]};
	end

	always_comb begin
		case (cmd)
			sbsm_pkg::CMD_CPU_READ: offset = cpu_off;
			sbsm_pkg::CMD_PPU_READ: offset = ppu_off;
			default:                offset = '0;
		endcase
	end

endmodule

/* test/sbsm_translation_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbsm_translation_checker
// Watches the access, result and configuration channels of the mapper, keeps
// its own copy of the bank registers and serial loader, predicts each result
// and compares it with what comes out on m_axis, oldest first.
// ---------------------------------------------------------------------------
module sbsm_translation_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [23:0] m_axis_tdata,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [4:0]  cfg_data,
	output int          mismatch_count,
	output int          results_owed
);

	typedef struct {
		logic [sbsm_pkg::OFFSET_W-1:0] offset;
		logic [sbsm_pkg::MIRROR_W-1:0] mirror;
	} translation_t;

	translation_t                 owed_translations[$];
	logic [sbsm_pkg::COUNT_W-1:0] prg_count;
	logic [sbsm_pkg::COUNT_W-1:0] chr_count;
	logic [4:0]                   shift_reg;
	logic [2:0]                   shift_cnt;
	sbsm_pkg::bank_state_t        banks;

	function automatic logic [sbsm_pkg::OFFSET_W-1:0] cpu_offset(
			logic [sbsm_pkg::ADDR_W-1:0] a);
		logic [31:0] o;
		if (banks.control[3] && a >= 16'h8000) begin
			if (a <= 16'hBFFF)
				o = 32'(banks.prg_low) * 32'h4000 + 32'(a[13:0]);
			else
				o = 32'(banks.prg_high) * 32'h4000 + 32'(a[13:0]);
		end else begin
			o = 32'(banks.prg_whole) * 32'h8000 + 32'(a[14:0]);
		end
		return o[sbsm_pkg::OFFSET_W-1:0];
	endfunction

	function automatic logic [sbsm_pkg::OFFSET_W-1:0] ppu_offset(
			logic [sbsm_pkg::ADDR_W-1:0] a);
		logic [31:0] o;
		if (chr_count == '0)
			o = 32'(a);
		else if (banks.control[4]) begin
			if (a < 16'h1000)
				o = 32'(banks.chr_low) * 32'h1000 + 32'(a[11:0]);
			else if (a < 16'h2000)
				o = 32'(banks.chr_high) * 32'h1000 + 32'(a[11:0]);
			else
				o = 32'(sbsm_pkg::PPU_OUT_OF_RANGE);
		end else begin
			// 8 KiB mode: bank index forced even
			o = 32'(banks.chr_whole & 5'h1E) * 32'h1000 + 32'(a[12:0]);
		end
		return o[sbsm_pkg::OFFSET_W-1:0];
	endfunction

	task automatic load_target(logic [sbsm_pkg::ADDR_W-1:0] a, logic [4:0] value);
		sbsm_pkg::target_t tgt;
		logic              chr4;
		tgt  = sbsm_pkg::target_t'(a[14:13]);
		chr4 = banks.control[4];
		case (tgt)
			sbsm_pkg::TGT_CONTROL: banks.control = value;
			sbsm_pkg::TGT_CHR_LOW: begin
				if (chr4)
					banks.chr_low = value;
				else
					banks.chr_whole = value & 5'h1E;
			end
			sbsm_pkg::TGT_CHR_HIGH: begin
				// dropped in 8 KiB mode
				if (chr4)
					banks.chr_high = value;
			end
			sbsm_pkg::TGT_PRG: begin
				if (!banks.control[3]) begin
					// 32 KiB mode
					banks.prg_whole = value[3:1];
				end else if (!banks.control[2]) begin
					// low fixed at first bank
					banks.prg_low  = '0;
					banks.prg_high = value[3:0];
				end else begin
					// high fixed at last bank, count read now
					banks.prg_low  = value[3:0];
					banks.prg_high = 4'(prg_count - 5'd1);
				end
			end
		endcase
	endtask

	task automatic serial_write(logic [sbsm_pkg::ADDR_W-1:0] a,
			logic [sbsm_pkg::DATA_W-1:0] d);
		if (d[7]) begin
			shift_reg = '0;
			shift_cnt = '0;
			banks.control = banks.control | sbsm_pkg::CTRL_PRG_16K;
		end else begin
			shift_reg = {d[0], shift_reg[4:1]};
			shift_cnt = shift_cnt + 3'd1;
			if (shift_cnt == sbsm_pkg::SERIAL_LAST) begin
				load_target(a, shift_reg);
				shift_reg = '0;
				shift_cnt = '0;
			end
		end
	endtask

	task automatic translate(sbsm_pkg::cmd_t c, logic [sbsm_pkg::ADDR_W-1:0] a,
			logic [sbsm_pkg::DATA_W-1:0] d, output translation_t r);
		r.offset = '0;
		case (c)
			sbsm_pkg::CMD_CPU_READ:  r.offset = cpu_offset(a);
			sbsm_pkg::CMD_CPU_WRITE: serial_write(a, d);
			sbsm_pkg::CMD_PPU_READ:  r.offset = ppu_offset(a);
			default:                 r.offset = '0;
		endcase
		r.mirror = banks.control[1:0];
	endtask

	always @(posedge clk or negedge arst_n) begin
		translation_t want;
		translation_t got;
		if (!arst_n) begin
			owed_translations.delete();
			prg_count       = sbsm_pkg::PRG_COUNT_RESET;
			chr_count       = sbsm_pkg::CHR_COUNT_RESET;
			shift_reg       = '0;
			shift_cnt       = '0;
			banks           = '0;
			banks.control   = sbsm_pkg::CTRL_RESET;
			banks.prg_high  = sbsm_pkg::PRG_HIGH_RESET;
			mismatch_count  = 0;
			results_owed    = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.offset = m_axis_tdata[17:0];
				got.mirror = m_axis_tdata[19:18];
				if (owed_translations.size() == 0) begin
					$error("unexpected result: mapped_offset 0x%05h mirror_mode %0d",
						got.offset, got.mirror);
					mismatch_count++;
				end else begin
					want = owed_translations.pop_front();
					if (got.offset !== want.offset) begin
						$error("mapped_offset: expected 0x%05h, actual 0x%05h",
							want.offset, got.offset);
						mismatch_count++;
					end
					if (got.mirror !== want.mirror) begin
						$error("mirror_mode: expected %0d, actual %0d",
							want.mirror, got.mirror);
						mismatch_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (sbsm_pkg::cfg_index_t'(cfg_index))
					sbsm_pkg::CFG_PRG_COUNT: prg_count = cfg_data;
					sbsm_pkg::CFG_CHR_COUNT: chr_count = cfg_data;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				translate(sbsm_pkg::cmd_t'(s_axis_tdata[1:0]), s_axis_tdata[17:2],
					s_axis_tdata[25:18], want);
				owed_translations.push_back(want);
			end
			results_owed = owed_translations.size();
		end
	end

endmodule

/* test/tb_serial_bank_switch_mapper.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_serial_bank_switch_mapper
// Drives bus accesses and bank count writes into the serial bank switch
// mapper: a short directed pass over address extremes, loader resets and
// the PPU out-of-range case, then random phases of serial loads and reads
// under several bank count settings, with random stalls on both streams.
// A separate checker predicts and compares every result.
// ---------------------------------------------------------------------------
module tb_serial_bank_switch_mapper;

	// serial load with no loader reset injected
	localparam int NO_BREAK = 5;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;   // [1:0] command, [17:2] address, [25:18] data
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;   // [17:0] mapped_offset, [19:18] mirror_mode
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [4:0]  cfg_data;

	int          mismatch_count;
	int          results_owed;
	int          accesses_sent;
	bit          calm;           // set for the final phase: no idling anywhere

	serial_bank_switch_mapper dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	sbsm_translation_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.results_owed   (results_owed)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result side: random stall bursts, none once calm.
	initial begin
		int stall_left;
		stall_left    = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 11) - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("tb_serial_bank_switch_mapper NOT OK");
		$finish;
	end

	// One access transfer. Called at a falling edge; returns at the falling
	// edge after acceptance with tvalid still high, so back-to-back accesses
	// keep tvalid up without a glitch.
	task automatic push_access(sbsm_pkg::cmd_t c, logic [15:0] a, logic [7:0] d);
		int gap;
		if (!calm && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 11);
			if (s_axis_tvalid)
				s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {6'd0, d, a, c};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		accesses_sent++;
	endtask

	// Always waits on a falling edge before it checks, so an earlier tvalid drop
	// lands in a different time step than the next raise.
	task automatic wait_drained();
		do @(negedge clk); while (results_owed != 0);
	endtask

	// Both bank counts back to back; cfg_valid stays up between them.
	task automatic write_bank_counts(logic [4:0] prg, logic [4:0] chr);
		cfg_valid <= 1'b1;
		cfg_index <= sbsm_pkg::CFG_PRG_COUNT;
		cfg_data  <= prg;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_index <= sbsm_pkg::CFG_CHR_COUNT;
		cfg_data  <= chr;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Five serial writes loading value into the register picked by address
	// bits 14:13. break_at injects a loader reset at that write instead;
	// mixed sprinkles reads between the writes, which must not disturb the
	// shift register.
	task automatic serial_load(logic [15:0] a, logic [4:0] value, int break_at, bit mixed);
		for (int i = 0; i < 5; i++) begin
			if (mixed && $urandom_range(0, 3) == 0)
				push_access($urandom_range(0, 1) ? sbsm_pkg::CMD_CPU_READ
					: sbsm_pkg::CMD_PPU_READ, 16'($urandom), 8'($urandom));
			if (i == break_at) begin
				push_access(sbsm_pkg::CMD_CPU_WRITE, a, 8'h80 | 8'($urandom));
				return;
			end
			push_access(sbsm_pkg::CMD_CPU_WRITE, a, {1'b0, 6'($urandom), value[i]});
		end
	endtask

	// Noise: any command, any address, any data. Stray writes may reset
	// or advance the loader.
	task automatic random_access();
		int             pick;
		logic [15:0]    a;
		sbsm_pkg::cmd_t c;
		pick = $urandom_range(0, 9);
		a    = 16'($urandom);
		if (pick < 4) begin
			c = sbsm_pkg::CMD_CPU_READ;
		end else if (pick < 7) begin
			c = sbsm_pkg::CMD_PPU_READ;
			// mostly within 0x0000-0x3FFF, sometimes any address
			if ($urandom_range(0, 3) != 0)
				a = 16'($urandom_range(0, 16'h3FFF));
		end else if (pick == 7) begin
			c = sbsm_pkg::CMD_UNUSED;
		end else begin
			c = sbsm_pkg::CMD_CPU_WRITE;
		end
		push_access(c, a, 8'($urandom));
	endtask

	// Drain, set new bank counts while idle, then about n random accesses,
	// half of the picks being serial loads of random content, some cut short.
	task automatic run_phase(logic [4:0] prg, logic [4:0] chr, int n);
		int stop;
		s_axis_tvalid <= 1'b0;
		wait_drained();
		write_bank_counts(prg, chr);
		stop = accesses_sent + n;
		while (accesses_sent < stop) begin
			if ($urandom_range(0, 9) < 5)
				serial_load(16'($urandom), 5'($urandom),
					($urandom_range(0, 7) == 0) ? $urandom_range(0, 4) : NO_BREAK, 1'b1);
			else
				random_access();
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		calm          = 1'b0;
		accesses_sent = 0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_valid     = 1'b0;
		cfg_index     = sbsm_pkg::CFG_PRG_COUNT;
		cfg_data      = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Smallest PRG count, largest CHR count; high PRG bank keeps its
		// reset value until the next PRG load in fixed-high mode.
		write_bank_counts(5'd1, 5'd16);

		// CPU address extremes in 16 KiB mode from reset
		push_access(sbsm_pkg::CMD_CPU_READ, 16'h0000, 8'h00);
		push_access(sbsm_pkg::CMD_CPU_READ, 16'h7FFF, 8'hFF);
		push_access(sbsm_pkg::CMD_CPU_READ, 16'h8000, 8'h00);
		push_access(sbsm_pkg::CMD_CPU_READ, 16'hBFFF, 8'h00);
		push_access(sbsm_pkg::CMD_CPU_READ, 16'hC000, 8'h00);
		push_access(sbsm_pkg::CMD_CPU_READ, 16'hFFFF, 8'h00);
		// PPU read in 8 KiB CHR mode, address past the pattern tables
		push_access(sbsm_pkg::CMD_PPU_READ, 16'h2000, 8'h00);
		// unused command leaves everything alone
		push_access(sbsm_pkg::CMD_UNUSED, 16'hFFFF, 8'hFF);
		// three shifts, then a loader reset
		push_access(sbsm_pkg::CMD_CPU_WRITE, 16'h8000, 8'h01);
		push_access(sbsm_pkg::CMD_CPU_WRITE, 16'h8000, 8'h7F);
		push_access(sbsm_pkg::CMD_CPU_WRITE, 16'h8000, 8'h01);
		push_access(sbsm_pkg::CMD_CPU_WRITE, 16'hFFFF, 8'hFF);
		// control: 4 KiB CHR, fixed-high PRG mode, horizontal mirroring
		serial_load(16'h9FFF, 5'h1F, NO_BREAK, 1'b0);
		// PPU above 0x1FFF in 4 KiB mode gives the out-of-range marker
		push_access(sbsm_pkg::CMD_PPU_READ, 16'h2000, 8'h00);
		push_access(sbsm_pkg::CMD_PPU_READ, 16'hFFFF, 8'h00);
		// PRG load in fixed-high mode picks up the new count
		serial_load(16'hE000, 5'h1F, NO_BREAK, 1'b0);
		push_access(sbsm_pkg::CMD_CPU_READ, 16'hFFFF, 8'h00);

		run_phase(5'd16, 5'd16, 110);
		run_phase(5'd1, 5'd0, 110);
		run_phase(5'($urandom_range(1, 16)), 5'($urandom_range(0, 16)), 110);
		calm = 1'b1;
		run_phase(5'($urandom_range(1, 16)), 5'($urandom_range(1, 16)), 70);

		s_axis_tvalid <= 1'b0;
		wait_drained();
		// wait for any stray result past the two-stage pipeline
		repeat (10) @(negedge clk);
		if (mismatch_count == 0)
			$display("tb_serial_bank_switch_mapper OK");
		else
			$display("tb_serial_bank_switch_mapper NOT OK");
		$finish;
	end

endmodule

/* files.f */
hdl/sbsm_pkg.sv
hdl/sbsm_loader.sv
hdl/sbsm_translate.sv
hdl/serial_bank_switch_mapper.sv
test/sbsm_translation_checker.sv
test/tb_serial_bank_switch_mapper.sv
